### src/dq_pkg.sv
// Shared types and constants for the double-ended queue.
package dq_pkg;

  localparam int unsigned WordWidth    = 32;
  localparam int unsigned DefaultDepth = 16;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_REAR  = 3'd5,
    OP_QUERY      = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

endpackage

### src/double_ended_queue.sv
// Double-ended queue of signed 32-bit words held in a circular on-chip buffer.
//
// The queue keeps up to DEPTH words in a synchronous RAM, tracked by a head
// index and an entry count held in flip-flops. Each item on the input channel
// is one request: push at the front or rear, pop from the front or rear, peek
// at either end, or an empty query (the unused opcode acts as a query). Every
// request yields exactly one result item carrying the read word, a status
// (ok, empty, or full), an empty flag and the occupancy after the request.
// Pushes, queries and requests refused for an empty or full queue are answered
// from the decode. A pop or peek that finds an entry also passes through S_READ,
// because the RAM read port returns its data in the cycle after the address is presented; while
// that read is outstanding the input is stalled, which also keeps a following
// write from touching the RAM before the read has completed. A result waits in
// the output register until taken, and a new request is accepted in the same
// cycle that the previous result leaves.
module double_ended_queue #(
  parameter int unsigned DEPTH = dq_pkg::DefaultDepth,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [2:0]                          opcode_i,
  input  logic signed [dq_pkg::WordWidth-1:0] push_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [dq_pkg::WordWidth-1:0] read_value_o,
  output logic [1:0]                          status_o,
  output logic                                is_empty_o,
  output logic [CW-1:0]                       occupancy_o
);

  localparam int unsigned SW = AW + 2;
  localparam int unsigned WW = dq_pkg::WordWidth;

  dq_pkg::state_e  state_q, state_d;
  logic [AW-1:0]   head_q, head_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  logic [WW-1:0]   value_q;
  dq_pkg::status_e status_q;
  logic            empty_q;
  logic [CW-1:0]   occ_q;

  dq_pkg::op_e     op;
  logic            accept;
  logic            out_free;
  logic            q_full;
  logic            q_empty;
  logic [AW-1:0]   head_dec;
  logic [AW-1:0]   head_inc;
  logic [SW-1:0]   tail_sum;
  logic [SW-1:0]   rear_sum;
  logic [AW-1:0]   tail_idx;
  logic [AW-1:0]   rear_idx;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic            rd_needed;
  logic [AW-1:0]   ram_raddr;
  logic [WW-1:0]   ram_rdata;
  logic [WW-1:0]   res_value;
  dq_pkg::status_e res_status;

  assign op      = dq_pkg::op_e'(opcode_i);
  assign q_full  = (cnt_q == CW'(DEPTH));
  assign q_empty = (cnt_q == '0);

  // Index arithmetic stays modulo DEPTH, which need not be a power of two.
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign tail_sum = SW'(head_q) + SW'(cnt_q);
  assign rear_sum = tail_sum - SW'(1);
  assign tail_idx = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
  assign rear_idx = (rear_sum >= SW'(DEPTH)) ? AW'(rear_sum - SW'(DEPTH)) : AW'(rear_sum);

  // Request decode: pointer updates, RAM access and the immediate answer.
  always_comb begin
    head_d     = head_q;
    cnt_d      = cnt_q;
    ram_we     = 1'b0;
    ram_waddr  = head_q;
    rd_needed  = 1'b0;
    ram_raddr  = head_q;
    res_value  = '0;
    res_status = dq_pkg::STAT_OK;
    unique case (op)
      dq_pkg::OP_PUSH_FRONT: begin
        if (q_full) begin
          res_status = dq_pkg::STAT_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = head_dec;
          head_d    = head_dec;
          cnt_d     = cnt_q + CW'(1);
        end
      end
      dq_pkg::OP_PUSH_REAR: begin
        if (q_full) begin
          res_status = dq_pkg::STAT_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = tail_idx;
          cnt_d     = cnt_q + CW'(1);
        end
      end
      dq_pkg::OP_POP_FRONT, dq_pkg::OP_PEEK_FRONT: begin
        if (q_empty) begin
          res_value  = '1;
          res_status = dq_pkg::STAT_EMPTY;
        end else begin
          rd_needed = 1'b1;
          ram_raddr = head_q;
          if (op == dq_pkg::OP_POP_FRONT) begin
            head_d = head_inc;
            cnt_d  = cnt_q - CW'(1);
          end
        end
      end
      dq_pkg::OP_POP_REAR, dq_pkg::OP_PEEK_REAR: begin
        if (q_empty) begin
          res_value  = '1;
          res_status = dq_pkg::STAT_EMPTY;
        end else begin
          rd_needed = 1'b1;
          ram_raddr = rear_idx;
          if (op == dq_pkg::OP_POP_REAR) begin
            cnt_d = cnt_q - CW'(1);
          end
        end
      end
      default: begin
        // Empty query and the unused opcode only report the current state.
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dq_pkg::S_IDLE: begin
        if (accept && rd_needed) begin
          state_d = dq_pkg::S_READ;
        end
      end
      dq_pkg::S_READ: begin
        state_d = dq_pkg::S_IDLE;
      end
      default: begin
        state_d = dq_pkg::S_IDLE;
      end
    endcase
  end

  // Handshake outputs. A request is taken only when the output register will
  // be empty after this edge, so a read result always finds room in the next cycle.
  always_comb begin
    out_free   = !out_valid_q || !out_stall_i;
    in_stall_o = (state_q != dq_pkg::S_IDLE) || !out_free;
  end

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && !rd_needed) begin
      out_valid_d = 1'b1;
    end else if (state_q == dq_pkg::S_READ) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  dq_ram #(
    .Depth(DEPTH),
    .Width(WW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (accept && ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(push_value_i),
    .re_i   (accept && rd_needed),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dq_pkg::S_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        head_q <= head_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  // Result payload. Status, flag and count are settled at acceptance; the word
  // of a successful pop or peek arrives from the RAM in the following cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q  <= res_value;
      status_q <= res_status;
      empty_q  <= (cnt_d == '0);
      occ_q    <= cnt_d;
    end else if (state_q == dq_pkg::S_READ) begin
      value_q <= ram_rdata;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = value_q;
  assign status_o     = status_q;
  assign is_empty_o   = empty_q;
  assign occupancy_o  = occ_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dq_pkg::S_READ) |-> !out_valid_q)
    else $error("output register busy while a read completes");

  a_read_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && rd_needed) |=> (state_q == dq_pkg::S_READ) && !out_valid_q)
    else $error("pop or peek did not enter the read cycle");

  a_read_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dq_pkg::S_READ) |=> out_valid_q && (state_q == dq_pkg::S_IDLE))
    else $error("read result not presented");

endmodule

### src/dq_ram.sv
// Slot storage of the queue: one write port and one registered read port.
module dq_ram #(
  parameter int unsigned Depth = dq_pkg::DefaultDepth,
  parameter int unsigned Width = dq_pkg::WordWidth,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### verif/tb.sv
// Self-checking testbench for the double-ended queue, with its scoreboard and driving tasks.
module tb;

  localparam int unsigned WordWidth  = dq_pkg::WordWidth;
  localparam int unsigned Depth      = dq_pkg::DefaultDepth;
  localparam int unsigned OccWidth   = $clog2(Depth + 1);
  localparam int unsigned IdxWidth   = $clog2(Depth);
  localparam int unsigned RandItems  = 1400;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 8;
  localparam int unsigned ShownMax   = 10;

  // The opcode left unused by the package acts as an empty query.
  localparam logic [2:0] OpUnused = 3'd7;

  // One result item as the block should present it.
  typedef struct packed {
    logic signed [WordWidth-1:0] value;
    logic [1:0]                  status;
    logic                        empty;
    logic [OccWidth-1:0]         occ;
  } deque_answer_t;

  // The scoreboard keeps its own copy of the queue. Every accepted request is
  // applied to that copy at once and the answer it must produce is queued.
  // Result items are then matched in order against the queued answers.
  class deque_scoreboard;
    logic [WordWidth-1:0] words [Depth];
    logic [IdxWidth-1:0]  head;
    logic [OccWidth-1:0]  count;
    deque_answer_t        answers [$];
    int unsigned          failures;

    function new();
      head     = '0;
      count    = '0;
      failures = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function int unsigned pending();
      return answers.size();
    endfunction

    function void note_request(logic [2:0] op, logic [WordWidth-1:0] word);
      deque_answer_t       ans;
      logic [IdxWidth-1:0] pos;
      ans = '0;
      case (op)
        dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_REAR: begin
          if (count == Depth) begin
            ans.status = dq_pkg::STAT_FULL;
          end else if (op == dq_pkg::OP_PUSH_FRONT) begin
            head        = head - 1'b1;
            words[head] = word;
            count       = count + 1'b1;
          end else begin
            pos         = head + count[IdxWidth-1:0];
            words[pos]  = word;
            count       = count + 1'b1;
          end
        end
        dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_REAR,
        dq_pkg::OP_PEEK_FRONT, dq_pkg::OP_PEEK_REAR: begin
          if (count == 0) begin
            ans.value  = -1;
            ans.status = dq_pkg::STAT_EMPTY;
          end else begin
            if (op == dq_pkg::OP_POP_FRONT || op == dq_pkg::OP_PEEK_FRONT) begin
              pos = head;
            end else begin
              pos = head + count[IdxWidth-1:0] - 1'b1;
            end
            ans.value = words[pos];
            if (op == dq_pkg::OP_POP_FRONT) begin
              head  = head + 1'b1;
              count = count - 1'b1;
            end else if (op == dq_pkg::OP_POP_REAR) begin
              count = count - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      ans.empty = (count == 0);
      ans.occ   = count;
      answers.push_back(ans);
    endfunction

    function void check_result(logic signed [WordWidth-1:0] value, logic [1:0] status,
                               logic empty, logic [OccWidth-1:0] occ);
      deque_answer_t exp;
      bit            bad;
      if (answers.size() == 0) begin
        failures++;
        if (failures <= ShownMax) begin
          $display("unexpected result: value %0d status %0d empty %0b occ %0d",
                   value, status, empty, occ);
        end
        return;
      end
      exp = answers.pop_front();
      bad = 1'b0;
      if (value !== exp.value) bad = 1'b1;
      if (status !== exp.status) bad = 1'b1;
      if (empty !== exp.empty) bad = 1'b1;
      if (occ !== exp.occ) bad = 1'b1;
      if (bad) begin
        failures++;
        if (failures <= ShownMax) begin
          $display("mismatch: value %0d/%0d status %0d/%0d empty %0b/%0b occ %0d/%0d (exp/act)",
                   exp.value, value, exp.status, status, exp.empty, empty, exp.occ, occ);
        end
      end
    endfunction
  endclass

  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        in_valid     = 1'b0;
  logic [2:0]                  opcode       = dq_pkg::OP_QUERY;
  logic signed [WordWidth-1:0] push_value   = '0;
  logic                        out_stall    = 1'b0;
  logic                        in_stall;
  logic                        out_valid;
  logic signed [WordWidth-1:0] read_value;
  logic [1:0]                  status;
  logic                        is_empty;
  logic [OccWidth-1:0]         occupancy;

  // Percentages of cycles in which the sender holds back and the receiver
  // stalls; the main sequence changes them from phase to phase.
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     cycles = 0;
  deque_scoreboard board = new();

  double_ended_queue #(
    .DEPTH(Depth)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .opcode_i    (opcode),
    .push_value_i(push_value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .read_value_o(read_value),
    .status_o    (status),
    .is_empty_o  (is_empty),
    .occupancy_o (occupancy)
  );

  always #1 clk_i = ~clk_i;

  // The run is bounded so that a hung handshake cannot keep it going forever.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("** double_ended_queue: FAILED **");
      $finish;
    end
  end

  // Receiver side. Outputs are sampled at the edge, before the block's own
  // registers move, and the stall for the next cycle is chosen at the same
  // edge with a single nonblocking assignment.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      board.check_result(read_value, status, is_empty, occupancy);
    end
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Offers one request and returns at the edge where it was accepted. Sender
  // gaps are drawn cycle by cycle before the request goes out, so valid only
  // ever drops between items and never while one is being offered.
  task automatic send_request(logic [2:0] op, logic [WordWidth-1:0] word);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    push_value <= word;
    do @(posedge clk_i); while (in_stall);
    board.note_request(op, word);
  endtask

  // Mostly full-range random words, with the corner words mixed in.
  function automatic logic [WordWidth-1:0] pick_word();
    case ($urandom_range(19))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Random requests come in fill and drain stretches, so the queue keeps
  // sweeping between empty and full and both refusals are hit often. Peeks,
  // queries and the unused opcode are sprinkled in as noise.
  task automatic run_random(int unsigned n);
    bit          filling;
    int unsigned r;
    logic [2:0]  op;
    filling = 1'($urandom_range(1));
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(99) < 4) filling = !filling;
      if (filling && board.count == Depth && $urandom_range(3) == 0) filling = 1'b0;
      if (!filling && board.count == 0 && $urandom_range(3) == 0) filling = 1'b1;
      r = $urandom_range(99);
      if (r < 70) begin
        // Push or pop, weighted by the current stretch.
        if ((r < 50) == filling) begin
          op = $urandom_range(1) ? dq_pkg::OP_PUSH_REAR : dq_pkg::OP_PUSH_FRONT;
        end else begin
          op = $urandom_range(1) ? dq_pkg::OP_POP_REAR : dq_pkg::OP_POP_FRONT;
        end
      end else if (r < 90) begin
        op = $urandom_range(1) ? dq_pkg::OP_PEEK_REAR : dq_pkg::OP_PEEK_FRONT;
      end else if (r < 96) begin
        op = dq_pkg::OP_QUERY;
      end else begin
        op = OpUnused;
      end
      send_request(op, pick_word());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue: every read is refused, queries report empty.
    send_request(dq_pkg::OP_PEEK_FRONT, pick_word());
    send_request(dq_pkg::OP_PEEK_REAR, pick_word());
    send_request(dq_pkg::OP_POP_FRONT, pick_word());
    send_request(dq_pkg::OP_POP_REAR, pick_word());
    send_request(dq_pkg::OP_QUERY, 32'hFFFF_FFFF);
    send_request(OpUnused, 32'h0);
    // Extreme words at both ends.
    send_request(dq_pkg::OP_PUSH_REAR, 32'h7FFF_FFFF);
    send_request(dq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
    send_request(dq_pkg::OP_QUERY, 32'h0);
    send_request(dq_pkg::OP_PEEK_FRONT, 32'h0);
    send_request(dq_pkg::OP_PEEK_REAR, 32'h0);
    // Pop from the rear down to empty, through the single-entry case.
    send_request(dq_pkg::OP_POP_REAR, 32'h0);
    send_request(dq_pkg::OP_POP_REAR, 32'h0);
    send_request(dq_pkg::OP_QUERY, 32'h0);
    // Popping the only entry from the front must leave no stale rear behind.
    send_request(dq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_request(dq_pkg::OP_POP_FRONT, 32'h0);
    send_request(dq_pkg::OP_PUSH_REAR, 32'h0);
    send_request(dq_pkg::OP_PEEK_REAR, 32'h0);
    send_request(dq_pkg::OP_POP_FRONT, 32'h0);

    // Random traffic under three backpressure profiles.
    send_idle_pct  = 18;
    recv_stall_pct = 52;
    run_random(RandItems / 3);
    send_idle_pct  = 52;
    recv_stall_pct = 18;
    run_random(RandItems / 3);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(RandItems - 2 * (RandItems / 3));

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (board.failures == 0) begin
      $display("** double_ended_queue: PASSED **");
    end else begin
      $display("** double_ended_queue: FAILED **");
    end
    $finish;
  end

endmodule
